// ===== hw/rtl/kts_pkg.sv =====
// Shared widths, codes, state type, key word type and divider handshake types for the keyframe track sampler.
package kts_pkg;

    localparam int TIME_W      = 32;
    localparam int VAL_W       = 32;
    localparam int KEY_IDX_W   = 6;
    localparam int BLEND_W     = 17;
    localparam int FRAC_W      = 16;
    localparam int KEY_COUNT_W = 7;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 7;
    localparam int MAX_KEYS_DEF = 64;
    localparam int DIV_STEPS   = 17;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS + 1);
    localparam int DIFF_W      = VAL_W + 1;
    localparam int PROD_W      = DIFF_W + BLEND_W + 1;
    localparam int COMP_W      = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_KEY_COUNT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_MODE = 1'd1;

    localparam logic REQ_LOAD   = 1'b0;
    localparam logic REQ_SAMPLE = 1'b1;

    localparam logic [COMP_W-1:0] COMP_X = 2'd0;
    localparam logic [COMP_W-1:0] COMP_Y = 2'd1;
    localparam logic [COMP_W-1:0] COMP_Z = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHK0,
        S_CHKL,
        S_SCAN,
        S_DIV,
        S_RDA,
        S_RDB,
        S_MUL,
        S_ADD,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [TIME_W-1:0] key_time;
        logic [VAL_W-1:0]  val_x;
        logic [VAL_W-1:0]  val_y;
        logic [VAL_W-1:0]  val_z;
    } t_key_word;

    typedef struct packed {
        logic              start;
        logic [TIME_W-1:0] dividend;
        logic [TIME_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic               done;
        logic [BLEND_W-1:0] quotient;
    } t_div_rsp;

endpackage

// ===== hw/rtl/kts_ifs.sv =====
// Valid/ready channel interfaces for request beats and result beats.
interface kts_req_if;
    logic                             valid;
    logic                             ready;
    logic                             req_type;
    logic [kts_pkg::KEY_IDX_W-1:0]    key_index;
    logic [kts_pkg::TIME_W-1:0]       key_time;
    logic signed [kts_pkg::VAL_W-1:0] value_x;
    logic signed [kts_pkg::VAL_W-1:0] value_y;
    logic signed [kts_pkg::VAL_W-1:0] value_z;
    logic [kts_pkg::TIME_W-1:0]       sample_time;

    modport source (output valid, req_type, key_index, key_time, value_x, value_y, value_z,
                    sample_time, input ready);
    modport sink (input valid, req_type, key_index, key_time, value_x, value_y, value_z,
                  sample_time, output ready);
endinterface

interface kts_rsp_if;
    logic                             valid;
    logic                             ready;
    logic [kts_pkg::KEY_IDX_W-1:0]    first_key;
    logic [kts_pkg::KEY_IDX_W-1:0]    second_key;
    logic [kts_pkg::BLEND_W-1:0]      blend;
    logic signed [kts_pkg::VAL_W-1:0] out_x;
    logic signed [kts_pkg::VAL_W-1:0] out_y;
    logic signed [kts_pkg::VAL_W-1:0] out_z;

    modport source (output valid, first_key, second_key, blend, out_x, out_y, out_z,
                    input ready);
    modport sink (input valid, first_key, second_key, blend, out_x, out_y, out_z,
                  output ready);
endinterface

// ===== hw/rtl/kts_divider.sv =====
// Restoring divider giving floor(dividend * 65536 / divisor), one quotient bit per cycle.
module kts_divider (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  kts_pkg::t_div_req i_req,
    output kts_pkg::t_div_rsp o_rsp
);

    logic [kts_pkg::TIME_W:0]          r_rem;
    logic [kts_pkg::TIME_W-1:0]        r_div;
    logic [kts_pkg::BLEND_W-1:0]       r_q;
    logic [kts_pkg::DIV_CNT_W-1:0]     r_cnt;
    logic                              r_busy;
    logic                              r_done;
    logic [kts_pkg::TIME_W:0]          w_diff;
    logic                              w_bit;
    logic [kts_pkg::TIME_W-1:0]        w_keep;

    assign w_bit  = r_rem >= {1'b0, r_div};
    assign w_diff = r_rem - {1'b0, r_div};
    assign w_keep = w_bit ? w_diff[kts_pkg::TIME_W-1:0] : r_rem[kts_pkg::TIME_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= kts_pkg::DIV_CNT_W'(kts_pkg::DIV_STEPS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - kts_pkg::DIV_CNT_W'(1);
                if (r_cnt == kts_pkg::DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= {1'b0, i_req.dividend};
            r_div <= i_req.divisor;
            r_q   <= '0;
        end else if (r_busy) begin
            r_rem <= {w_keep, 1'b0};
            r_q   <= {r_q[kts_pkg::BLEND_W-2:0], w_bit};
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_q;

endmodule

// ===== hw/rtl/keyframe_track_sampler.sv =====
// Top level of the keyframe track sampler: key memory, search sequencer and shared lerp unit.
//
//   channel  dir  beat                       handshake
//   i_req    in   load one key or sample     valid/ready
//   o_rsp    out  keys, blend, x/y/z value   valid/ready
//   i_cfg    in   key_count, step_mode       write enable only
//
// A load beat is written in the cycle it is accepted and the block stays ready.
// A sample beat keeps the block busy while it checks the first key and, if needed, the last,
// searches the intervals linearly, runs the serial 17-step divider unless the blend is zero
// and lerps x, y and z in turn. The result beat shows on o_rsp in the cycle ready returns.
// Reset is synchronous; key memory contents are not cleared. A finished sample waits,
// and the block stays busy, while the result beat before it is still held on o_rsp.
module keyframe_track_sampler #(
    parameter int MAX_KEYS = kts_pkg::MAX_KEYS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [kts_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [kts_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    kts_req_if.sink                            i_req,
    kts_rsp_if.source                          o_rsp
);

    localparam int IW = $clog2(MAX_KEYS);
    localparam int SW = (kts_pkg::KEY_COUNT_W > IW + 1) ? kts_pkg::KEY_COUNT_W : IW + 1;

    kts_pkg::t_state                    r_state;
    kts_pkg::t_state                    n_state;
    logic [kts_pkg::KEY_COUNT_W-1:0]    r_key_count;
    logic                               r_step_mode;

    kts_pkg::t_key_word                 r_mem [MAX_KEYS];
    kts_pkg::t_key_word                 r_rd_data;
    logic [IW-1:0]                      w_rd_addr;

    logic [kts_pkg::TIME_W-1:0]         r_t;
    logic [kts_pkg::TIME_W-1:0]         r_lo;
    logic [IW-1:0]                      r_last;
    logic                               r_single;
    logic [IW-1:0]                      r_i;
    logic [IW-1:0]                      r_k0;
    logic [IW-1:0]                      r_k1;
    logic [kts_pkg::BLEND_W-1:0]        r_blend;
    logic [kts_pkg::COMP_W-1:0]         r_c;
    logic [kts_pkg::VAL_W-1:0]          r_a_x;
    logic [kts_pkg::VAL_W-1:0]          r_a_y;
    logic [kts_pkg::VAL_W-1:0]          r_a_z;
    logic signed [kts_pkg::PROD_W-1:0]  r_prod;
    logic [kts_pkg::VAL_W-1:0]          r_res_x;
    logic [kts_pkg::VAL_W-1:0]          r_res_y;
    logic [kts_pkg::VAL_W-1:0]          r_res_z;

    logic                               r_out_valid;
    logic [kts_pkg::KEY_IDX_W-1:0]      r_out_k0;
    logic [kts_pkg::KEY_IDX_W-1:0]      r_out_k1;
    logic [kts_pkg::BLEND_W-1:0]        r_out_blend;
    logic [kts_pkg::VAL_W-1:0]          r_out_x;
    logic [kts_pkg::VAL_W-1:0]          r_out_y;
    logic [kts_pkg::VAL_W-1:0]          r_out_z;

    logic                               w_in_acc;
    logic                               w_slot_ok;
    logic [SW-1:0]                      w_kc;
    logic [SW-1:0]                      w_n;
    logic [IW-1:0]                      w_i_inc;
    logic                               w_found;
    logic                               w_scan_end;
    logic                               w_blend_zero;
    logic                               w_out_load;
    logic [kts_pkg::VAL_W-1:0]          w_a_sel;
    logic [kts_pkg::VAL_W-1:0]          w_b_sel;
    logic signed [kts_pkg::DIFF_W-1:0]  w_diff;
    logic signed [kts_pkg::BLEND_W:0]   w_blend_s;
    logic signed [kts_pkg::PROD_W-1:0]  w_prod;
    logic [kts_pkg::VAL_W-1:0]          w_sum;
    kts_pkg::t_div_req                  w_div_req;
    kts_pkg::t_div_rsp                  w_div_rsp;

    kts_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    assign w_in_acc   = i_req.valid & i_req.ready;
    assign w_slot_ok  = 32'(i_req.key_index) < 32'(MAX_KEYS);
    assign w_kc       = SW'(r_key_count);
    assign w_n        = (w_kc == '0) ? SW'(1) : ((w_kc > SW'(MAX_KEYS)) ? SW'(MAX_KEYS) : w_kc);
    assign w_i_inc    = r_i + IW'(1);
    assign w_found    = (r_t >= r_lo) && (r_t <= r_rd_data.key_time);
    assign w_scan_end = (w_i_inc == r_last);
    assign w_blend_zero = r_step_mode || (r_rd_data.key_time == r_lo);
    assign w_out_load = (r_state == kts_pkg::S_DONE) && (!r_out_valid || o_rsp.ready);

    // Shared lerp datapath, one component per pass.
    always_comb begin
        case (r_c)
            kts_pkg::COMP_X: begin
                w_a_sel = r_a_x;
                w_b_sel = r_rd_data.val_x;
            end
            kts_pkg::COMP_Y: begin
                w_a_sel = r_a_y;
                w_b_sel = r_rd_data.val_y;
            end
            default: begin
                w_a_sel = r_a_z;
                w_b_sel = r_rd_data.val_z;
            end
        endcase
    end

    assign w_diff    = $signed({w_b_sel[kts_pkg::VAL_W-1], w_b_sel})
                     - $signed({w_a_sel[kts_pkg::VAL_W-1], w_a_sel});
    assign w_blend_s = $signed({1'b0, r_blend});
    assign w_prod    = w_diff * w_blend_s;
    assign w_sum     = w_a_sel + r_prod[kts_pkg::FRAC_W+kts_pkg::VAL_W-1:kts_pkg::FRAC_W];

    always_comb begin
        n_state = r_state;
        case (r_state)
            kts_pkg::S_IDLE: begin
                if (w_in_acc && i_req.req_type == kts_pkg::REQ_SAMPLE) begin
                    n_state = kts_pkg::S_CHK0;
                end
            end
            kts_pkg::S_CHK0: begin
                if (r_single || r_t <= r_rd_data.key_time) begin
                    n_state = kts_pkg::S_RDA;
                end else begin
                    n_state = kts_pkg::S_CHKL;
                end
            end
            kts_pkg::S_CHKL: begin
                if (r_t >= r_rd_data.key_time) begin
                    n_state = kts_pkg::S_RDA;
                end else begin
                    n_state = kts_pkg::S_SCAN;
                end
            end
            kts_pkg::S_SCAN: begin
                if (w_found) begin
                    n_state = w_blend_zero ? kts_pkg::S_RDA : kts_pkg::S_DIV;
                end else if (w_scan_end) begin
                    n_state = kts_pkg::S_RDA;
                end
            end
            kts_pkg::S_DIV: begin
                if (w_div_rsp.done) begin
                    n_state = kts_pkg::S_RDA;
                end
            end
            kts_pkg::S_RDA: n_state = kts_pkg::S_RDB;
            kts_pkg::S_RDB: n_state = kts_pkg::S_MUL;
            kts_pkg::S_MUL: n_state = kts_pkg::S_ADD;
            kts_pkg::S_ADD: begin
                n_state = (r_c == kts_pkg::COMP_Z) ? kts_pkg::S_DONE : kts_pkg::S_MUL;
            end
            kts_pkg::S_DONE: begin
                if (w_out_load) begin
                    n_state = kts_pkg::S_IDLE;
                end
            end
            default: n_state = kts_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        i_req.ready        = 1'b0;
        w_rd_addr          = r_k1;
        w_div_req.start    = 1'b0;
        w_div_req.dividend = r_t - r_lo;
        w_div_req.divisor  = r_rd_data.key_time - r_lo;
        case (r_state)
            kts_pkg::S_IDLE: begin
                i_req.ready = 1'b1;
                w_rd_addr   = '0;
            end
            kts_pkg::S_CHK0: w_rd_addr = r_last;
            kts_pkg::S_CHKL: w_rd_addr = IW'(1);
            kts_pkg::S_SCAN: begin
                w_rd_addr       = w_i_inc + IW'(1);
                w_div_req.start = w_found && !w_blend_zero;
            end
            kts_pkg::S_RDA: w_rd_addr = r_k0;
            default: w_rd_addr = r_k1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc && i_req.req_type == kts_pkg::REQ_LOAD && w_slot_ok) begin
            r_mem[IW'(i_req.key_index)] <= {i_req.key_time, i_req.value_x, i_req.value_y,
                                            i_req.value_z};
        end
        r_rd_data <= r_mem[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= kts_pkg::S_IDLE;
            r_key_count <= kts_pkg::KEY_COUNT_W'(1);
            r_step_mode <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    kts_pkg::CFG_KEY_COUNT: r_key_count <= i_cfg_data;
                    kts_pkg::CFG_STEP_MODE: r_step_mode <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            kts_pkg::S_IDLE: begin
                r_t      <= i_req.sample_time;
                r_last   <= IW'(w_n - SW'(1));
                r_single <= (w_n == SW'(1));
                r_k0     <= '0;
                r_k1     <= '0;
                r_blend  <= '0;
            end
            kts_pkg::S_CHK0: begin
                r_lo <= r_rd_data.key_time;
            end
            kts_pkg::S_CHKL: begin
                r_i <= '0;
                if (r_t >= r_rd_data.key_time) begin
                    r_k0 <= r_last;
                    r_k1 <= r_last;
                end
            end
            kts_pkg::S_SCAN: begin
                if (w_found) begin
                    r_k0 <= r_i;
                    r_k1 <= w_i_inc;
                end else begin
                    r_lo <= r_rd_data.key_time;
                    r_i  <= w_i_inc;
                    if (w_scan_end) begin
                        r_k0 <= r_last;
                        r_k1 <= r_last;
                    end
                end
            end
            kts_pkg::S_DIV: begin
                if (w_div_rsp.done) begin
                    r_blend <= w_div_rsp.quotient;
                end
            end
            kts_pkg::S_RDB: begin
                r_a_x <= r_rd_data.val_x;
                r_a_y <= r_rd_data.val_y;
                r_a_z <= r_rd_data.val_z;
                r_c   <= kts_pkg::COMP_X;
            end
            kts_pkg::S_MUL: begin
                r_prod <= w_prod;
            end
            kts_pkg::S_ADD: begin
                case (r_c)
                    kts_pkg::COMP_X: r_res_x <= w_sum;
                    kts_pkg::COMP_Y: r_res_y <= w_sum;
                    default:         r_res_z <= w_sum;
                endcase
                r_c <= r_c + kts_pkg::COMP_W'(1);
            end
            default: ;
        endcase
        if (w_out_load) begin
            r_out_k0    <= kts_pkg::KEY_IDX_W'(r_k0);
            r_out_k1    <= kts_pkg::KEY_IDX_W'(r_k1);
            r_out_blend <= r_blend;
            r_out_x     <= r_res_x;
            r_out_y     <= r_res_y;
            r_out_z     <= r_res_z;
        end
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.first_key  = r_out_k0;
    assign o_rsp.second_key = r_out_k1;
    assign o_rsp.blend      = r_out_blend;
    assign o_rsp.out_x      = r_out_x;
    assign o_rsp.out_y      = r_out_y;
    assign o_rsp.out_z      = r_out_z;

    a_rise_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == kts_pkg::S_DONE)
        else $error("Result beat appeared without a finished sample.");

    a_blend_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> o_rsp.blend <= kts_pkg::BLEND_W'(1 << kts_pkg::FRAC_W))
        else $error("Blend factor above one.");

    a_key_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> (o_rsp.second_key == o_rsp.first_key)
                     || (o_rsp.second_key == o_rsp.first_key + kts_pkg::KEY_IDX_W'(1)))
        else $error("Bracketing keys are not adjacent.");

    a_div_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_rsp.done |-> r_state == kts_pkg::S_DIV)
        else $error("Divider finished outside the divide step.");

endmodule
